FILE: design/hole_table_fit_allocator_core_defines.svh
`ifndef HOLE_TABLE_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define HOLE_TABLE_FIT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define HTFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/htfa_pkg.sv
`timescale 1ns / 1ps

package htfa_pkg;

  localparam int unsigned MAX_HOLES  = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_HOLES);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_HOLE_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] HOLE_COUNT_RESET = COUNT_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_RESTART = 2'd1,
    FUNC_ALLOC   = 2'd2
  } func_e;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } hole_t;

  typedef struct packed {
    logic fits;
    logic take;
  } fit_res_t;

endpackage

FILE: design/htfa_item_if.sv
`timescale 1ns / 1ps

interface htfa_in_if;
  import htfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [IDX_W-1:0]    hole_index;
  logic [ADDR_W-1:0]   hole_start;
  logic [SIZE_W-1:0]   amount;

  modport source (output valid, output func, output hole_index, output hole_start,
                  output amount, input ready);
  modport sink   (input valid, input func, input hole_index, input hole_start,
                  input amount, output ready);
endinterface

interface htfa_out_if;
  import htfa_pkg::*;

  logic                valid;
  logic                ready;
  logic                granted;
  logic [IDX_W-1:0]    chosen_hole;
  logic [ADDR_W-1:0]   base_address;

  modport source (output valid, output granted, output chosen_hole,
                  output base_address, input ready);
  modport sink   (input valid, input granted, input chosen_hole,
                  input base_address, output ready);
endinterface

FILE: design/htfa_fit_cmp.sv
`timescale 1ns / 1ps

module htfa_fit_cmp (
  input  htfa_pkg::policy_e              policy_i,
  input  logic                           entry_free_i,
  input  logic [htfa_pkg::SIZE_W-1:0]    entry_size_i,
  input  logic [htfa_pkg::SIZE_W-1:0]    req_i,
  input  logic                           have_pick_i,
  input  logic [htfa_pkg::SIZE_W-1:0]    best_size_i,
  output htfa_pkg::fit_res_t             res_o
);
  import htfa_pkg::*;

  logic fits;
  logic better;

  assign fits = entry_free_i && (entry_size_i >= req_i);

  always_comb begin
    case (policy_i)
      POL_BEST:  better = entry_size_i < best_size_i;
      POL_WORST: better = entry_size_i > best_size_i;
      default:   better = 1'b0;
    endcase
  end

  assign res_o.fits = fits;
  assign res_o.take = fits && (!have_pick_i || better);

endmodule

FILE: design/hole_table_fit_allocator_core.sv
`timescale 1ns / 1ps

// channel  dir  handshake        payload
// in_i     in   valid / ready    func, hole_index, hole_start, amount
// out_o    out  valid / ready    granted, chosen_hole, base_address
// apb      in   psel / penable   fit_policy at 0x0, hole_count at 0x4
//
// load and unused func codes finish at accept, restart copies hole_count table entries (capped at 16)
// allocate scans up to hole_count entries (capped at 16): one compare unit
// visits one table entry per cycle, then the chosen hole is updated
// first and next fit stop at the first hole that fits
// reset clears free bits, loaded marks, next pointer and config, tables are not cleared
// a pending result does not block accept, finishing waits for the output register

module hole_table_fit_allocator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  htfa_in_if.sink                           in_i,
  htfa_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [htfa_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [htfa_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [htfa_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import htfa_pkg::*;

`include "hole_table_fit_allocator_core_defines.svh"

  state_e                state_q, state_d;
  policy_e               policy_q;
  logic [COUNT_W-1:0]    hole_count_q;

  hole_t                 loaded_q [MAX_HOLES];
  hole_t                 work_q   [MAX_HOLES];
  logic [MAX_HOLES-1:0]  loaded_valid_q;
  logic [MAX_HOLES-1:0]  work_free_q;
  logic [IDX_W-1:0]      next_ptr_q;

  logic [IDX_W-1:0]      j_q;
  logic [IDX_W-1:0]      cnt_q;
  logic [SIZE_W-1:0]     req_q;
  logic                  have_q;
  logic [IDX_W-1:0]      pick_q;
  hole_t                 pick_hole_q;

  logic                  out_valid_q;
  logic                  out_granted_q;
  logic [IDX_W-1:0]      out_hole_q;
  logic [ADDR_W-1:0]     out_base_q;

  logic [CNT_W-1:0]      n_eff;
  logic                  in_fire;
  logic                  cfg_we;
  logic                  last_scan;
  logic                  last_copy;
  logic [IDX_W-1:0]      j_next;
  logic [IDX_W-1:0]      scan_first;
  logic                  stop_early;
  logic                  can_finish;
  logic                  load_we;
  logic                  restart_go;
  logic                  alloc_go;
  logic                  copy_we;
  logic                  upd_we;
  hole_t                 upd_hole;
  hole_t                 entry;
  fit_res_t              fit_res;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_FIT_POLICY: prdata = CFG_DATA_W'(policy_q);
      REG_HOLE_COUNT: prdata = CFG_DATA_W'(hole_count_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= POL_FIRST;
      hole_count_q <= HOLE_COUNT_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_FIT_POLICY: policy_q     <= policy_e'(pwdata[POLICY_W-1:0]);
        REG_HOLE_COUNT: hole_count_q <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // common control
  assign n_eff = (CNT_W'(hole_count_q) > CNT_W'(MAX_HOLES)) ? CNT_W'(MAX_HOLES)
                                                            : CNT_W'(hole_count_q);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign last_scan  = ({1'b0, cnt_q} == (n_eff - CNT_W'(1)));
  assign last_copy  = ({1'b0, j_q} == (n_eff - CNT_W'(1)));
  assign j_next     = (({1'b0, j_q} + CNT_W'(1)) == n_eff) ? '0 : j_q + IDX_W'(1);
  assign scan_first = (policy_q == POL_NEXT && {1'b0, next_ptr_q} < n_eff) ? next_ptr_q
                                                                           : '0;
  assign can_finish = !out_valid_q || out_o.ready;
  assign entry      = work_q[j_q];

  htfa_fit_cmp u_fit_cmp (
    .policy_i     (policy_q),
    .entry_free_i (work_free_q[j_q]),
    .entry_size_i (entry.size),
    .req_i        (req_q),
    .have_pick_i  (have_q),
    .best_size_i  (pick_hole_q.size),
    .res_o        (fit_res)
  );

  assign stop_early = fit_res.fits && (policy_q == POL_FIRST || policy_q == POL_NEXT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.func)
            FUNC_RESTART: state_d = (n_eff != '0) ? ST_COPY : ST_IDLE;
            FUNC_ALLOC:   state_d = (n_eff != '0) ? ST_SCAN : ST_FINISH;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_COPY:   if (last_copy) state_d = ST_IDLE;
      ST_SCAN:   if (stop_early || last_scan) state_d = ST_FINISH;
      ST_FINISH: if (can_finish) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    load_we    = 1'b0;
    restart_go = 1'b0;
    alloc_go   = 1'b0;
    copy_we    = 1'b0;
    upd_we     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        load_we    = in_fire && (in_i.func == FUNC_LOAD);
        restart_go = in_fire && (in_i.func == FUNC_RESTART);
        alloc_go   = in_fire && (in_i.func == FUNC_ALLOC);
      end
      ST_COPY:   copy_we = 1'b1;
      ST_FINISH: upd_we  = can_finish && have_q;
      default: ;
    endcase
  end

  assign upd_hole.start = pick_hole_q.start + req_q;
  assign upd_hole.size  = pick_hole_q.size - req_q;

  // hole tables
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      loaded_q[in_i.hole_index] <= '{start: in_i.hole_start, size: in_i.amount};
    end
    if (copy_we) begin
      work_q[j_q] <= loaded_q[j_q];
    end else if (upd_we) begin
      work_q[pick_q] <= upd_hole;
    end
  end

  // scan datapath
  always_ff @(posedge clk_i) begin
    if (restart_go) begin
      j_q <= '0;
    end else if (alloc_go) begin
      j_q   <= scan_first;
      cnt_q <= '0;
      req_q <= in_i.amount;
    end else if (copy_we) begin
      j_q <= j_q + IDX_W'(1);
    end else if (state_q == ST_SCAN) begin
      j_q   <= j_next;
      cnt_q <= cnt_q + IDX_W'(1);
      if (fit_res.take) begin
        pick_q      <= j_q;
        pick_hole_q <= entry;
      end
    end
    if (state_q == ST_FINISH && can_finish) begin
      out_granted_q <= have_q;
      out_hole_q    <= have_q ? pick_q : '0;
      out_base_q    <= have_q ? pick_hole_q.start : '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      loaded_valid_q <= '0;
      work_free_q    <= '0;
      next_ptr_q     <= '0;
      have_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_we) begin
        loaded_valid_q[in_i.hole_index] <= 1'b1;
      end
      if (copy_we) begin
        work_free_q[j_q] <= loaded_valid_q[j_q];
      end
      if (alloc_go) begin
        have_q <= 1'b0;
      end else if (state_q == ST_SCAN && fit_res.take) begin
        have_q <= 1'b1;
      end
      if (upd_we) begin
        if (upd_hole.size == '0) begin
          work_free_q[pick_q] <= 1'b0;
        end
        if (policy_q == POL_NEXT) begin
          next_ptr_q <= pick_q;
        end
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_FINISH && can_finish) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.granted      = out_granted_q;
  assign out_o.chosen_hole  = out_hole_q;
  assign out_o.base_address = out_base_q;

  `HTFA_ASSERT_NOW(a_scan_in_range, state_q == ST_SCAN, {1'b0, cnt_q} < n_eff, "scan past hole count")
  `HTFA_ASSERT_NOW(a_grant_in_range, out_valid_q && out_granted_q, {1'b0, out_hole_q} < n_eff, "granted hole out of range")
  `HTFA_ASSERT_NEXT(a_finish_gives_item, state_q == ST_FINISH && can_finish, out_valid_q && state_q == ST_IDLE, "finish without result item")

endmodule

FILE: tb/sv/tb_hole_table_fit_allocator_core.sv
`timescale 1ns / 1ps

module tb_hole_table_fit_allocator_core;
  import htfa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_POLICY = CFG_ADDR_W'(4 * int'(REG_FIT_POLICY));
  localparam logic [CFG_ADDR_W-1:0] ADDR_COUNT  = CFG_ADDR_W'(4 * int'(REG_HOLE_COUNT));
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  hole;
    logic [ADDR_W-1:0] base;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  htfa_in_if  in_ch ();
  htfa_out_if out_ch ();

  hole_table_fit_allocator_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // predicted block state
  policy_e            policy_q = POL_FIRST;
  logic [COUNT_W-1:0] hole_count_q = HOLE_COUNT_RESET;
  logic [SIZE_W-1:0]  ld_size  [MAX_HOLES];
  logic [ADDR_W-1:0]  ld_start [MAX_HOLES];
  bit                 ld_mark  [MAX_HOLES];
  logic [SIZE_W-1:0]  wk_size  [MAX_HOLES];
  logic [ADDR_W-1:0]  wk_start [MAX_HOLES];
  bit                 wk_free  [MAX_HOLES];
  logic [IDX_W-1:0]   next_ptr = '0;

  grant_t pending_grants [$];
  int     errors = 0;
  bit     no_gaps = 1'b0;
  int     rx_hold_cycles = 0;

  function automatic int find_hole(logic [SIZE_W-1:0] req, int n);
    int pick;
    int j;
    pick = -1;
    if (policy_q == POL_NEXT) begin
      j = (int'(next_ptr) < n) ? int'(next_ptr) : 0;
      for (int c = 0; c < n; c++) begin
        if (wk_free[j] && wk_size[j] >= req) begin
          next_ptr = IDX_W'(j);
          return j;
        end
        j = (j + 1 == n) ? 0 : j + 1;
      end
      return -1;
    end
    for (j = 0; j < n; j++) begin
      if (wk_free[j] && wk_size[j] >= req) begin
        if (policy_q == POL_FIRST) return j;
        if (pick < 0 ||
            (policy_q == POL_BEST && wk_size[j] < wk_size[pick]) ||
            (policy_q == POL_WORST && wk_size[j] > wk_size[pick]))
          pick = j;
      end
    end
    return pick;
  endfunction

  function automatic void table_update(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                       logic [ADDR_W-1:0] st, logic [SIZE_W-1:0] amt);
    int n;
    int pick;
    grant_t g;
    n = (int'(hole_count_q) > MAX_HOLES) ? MAX_HOLES : int'(hole_count_q);
    case (f)
      FUNC_LOAD: begin
        ld_start[idx] = st;
        ld_size[idx]  = amt;
        ld_mark[idx]  = 1'b1;
      end
      FUNC_RESTART: begin
        for (int j = 0; j < n; j++) begin
          wk_start[j] = ld_start[j];
          wk_size[j]  = ld_size[j];
          wk_free[j]  = ld_mark[j];
        end
      end
      FUNC_ALLOC: begin
        pick = find_hole(amt, n);
        if (pick < 0) begin
          g = '0;
        end else begin
          g.granted = 1'b1;
          g.hole    = IDX_W'(pick);
          g.base    = wk_start[pick];
          wk_start[pick] = wk_start[pick] + amt;
          wk_size[pick]  = wk_size[pick] - amt;
          if (wk_size[pick] == '0) wk_free[pick] = 1'b0;
        end
        pending_grants.push_back(g);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_grant(logic gr, logic [IDX_W-1:0] hole, logic [ADDR_W-1:0] base);
    grant_t e;
    if (pending_grants.size() == 0) begin
      $display("%0t: unexpected result granted=%0b hole=%0d base=%h", $time, gr, hole, base);
      errors++;
    end else begin
      e = pending_grants.pop_front();
      if (gr !== e.granted) begin
        $display("%0t: granted expected %0b actual %0b", $time, e.granted, gr);
        errors++;
      end
      if (hole !== e.hole) begin
        $display("%0t: chosen_hole expected %0d actual %0d", $time, e.hole, hole);
        errors++;
      end
      if (base !== e.base) begin
        $display("%0t: base_address expected %h actual %h", $time, e.base, base);
        errors++;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready)
      check_grant(out_ch.granted, out_ch.chosen_hole, out_ch.base_address);
    if (in_ch.valid && in_ch.ready)
      table_update(in_ch.func, in_ch.hole_index, in_ch.hole_start, in_ch.amount);
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  // result receiver
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(negedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = draw_gap();
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                           logic [ADDR_W-1:0] st, logic [SIZE_W-1:0] amt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.hole_index <= idx;
    in_ch.hole_start <= st;
    in_ch.amount     <= amt;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic load_hole(logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] st, logic [SIZE_W-1:0] sz);
    send_item(FUNC_LOAD, idx, st, sz);
  endtask

  task automatic restart_run();
    send_item(FUNC_RESTART, IDX_W'($urandom), ADDR_W'($urandom), SIZE_W'($urandom));
  endtask

  task automatic request(logic [SIZE_W-1:0] amt);
    send_item(FUNC_ALLOC, IDX_W'($urandom), ADDR_W'($urandom), amt);
  endtask

  task automatic drain_and_idle();
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_POLICY) policy_q = policy_e'(data[POLICY_W-1:0]);
    else hole_count_q = data[COUNT_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic program_regs(policy_e p, int c);
    drain_and_idle();
    apb_write(ADDR_POLICY, CFG_DATA_W'(p));
    apb_write(ADDR_COUNT, CFG_DATA_W'(c));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SIZE_W'($urandom_range(1, 16'h03FF));
  endfunction

  function automatic logic [SIZE_W-1:0] rand_amount();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(1, 16'h01FF));
  endfunction

  // never-loaded entries inside the count stay out of the search
  task automatic test_unloaded_entries();
    request(16'h0000);
    load_hole(4'd2, 16'h4000, 16'h0010);
    program_regs(POL_FIRST, 4);
    restart_run();
    request(16'h0000);
  endtask

  task automatic test_extreme_fields();
    load_hole(4'd0, 16'hFFFF, 16'h0001);
    load_hole(4'd1, 16'h0000, 16'h0000);
    load_hole(4'd2, 16'h1234, 16'h0100);
    load_hole(4'd3, 16'hFFF0, 16'hFFFF);
    restart_run();
    request(16'hFFFF);
    request(16'h0000);
    request(16'h0001);
    request(16'hFFFF);
  endtask

  task automatic test_policies();
    program_regs(POL_BEST, 4);
    request(16'h0000);
    program_regs(POL_WORST, 4);
    restart_run();
    request(16'h0001);
    program_regs(POL_NEXT, 4);
    request(16'h0200);
  endtask

  // pointer survives a restart, then goes stale under a smaller count
  task automatic test_stale_next_pointer();
    restart_run();
    request(16'h0000);
    program_regs(POL_NEXT, 2);
    request(16'h0000);
  endtask

  task automatic test_count_limits();
    program_regs(POL_FIRST, 0);
    request(16'h0000);
    program_regs(POL_WORST, 31);
    request(16'h0000);
  endtask

  task automatic test_unused_func();
    send_item(FUNC_UNUSED, IDX_W'($urandom), ADDR_W'($urandom), SIZE_W'($urandom));
    request(16'h0001);
  endtask

  task automatic test_output_backpressure();
    program_regs(POL_FIRST, 16);
    restart_run();
    rx_hold_cycles = LONG_HOLD;
    no_gaps = 1'b1;
    repeat (24) request(rand_amount());
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int sent;
    int r;
    int cnt;
    int hi;
    sent = 0;
    while (sent < 800) begin
      r = $urandom_range(0, 9);
      if (r == 0) cnt = 0;
      else if (r == 1) cnt = $urandom_range(17, 31);
      else if (r == 2) cnt = 16;
      else if (r == 3) cnt = 1;
      else cnt = $urandom_range(2, 15);
      program_regs(policy_e'($urandom_range(0, 3)), cnt);
      hi = (cnt == 0 || cnt > 16) ? 15 : cnt - 1;
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(6, 12)) begin
        if ($urandom_range(0, 9) < 8) begin
          repeat ($urandom_range(0, 4)) begin
            load_hole(IDX_W'($urandom_range(0, hi)), ADDR_W'($urandom), rand_size());
            sent++;
          end
          restart_run();
          sent++;
          repeat ($urandom_range(1, 8)) begin
            request(rand_amount());
            sent++;
          end
        end else begin
          r = $urandom_range(0, 3);
          send_item(FUNC_W'(r), IDX_W'($urandom), ADDR_W'($urandom), SIZE_W'($urandom));
          if (r != int'(FUNC_UNUSED)) sent++;
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_LOAD;
    in_ch.hole_index <= '0;
    in_ch.hole_start <= '0;
    in_ch.amount     <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_unloaded_entries();
    test_extreme_fields();
    test_policies();
    test_stale_next_pointer();
    test_count_limits();
    test_unused_func();
    test_output_backpressure();
    test_random_traffic();
    drain_and_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
